// ----- rtl/core/apc_pkg.sv -----
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the AOV pixel colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

  // Pipeline depth, output register included
  localparam int unsigned NStage = 4;

  // Fraction bits of the fixed-point magnitude
  localparam int unsigned FracBits = 48;

  // Width of the offset magnitude (one integer bit above the fraction)
  localparam int unsigned AccW = FracBits + 1;

  // Width of the magnitude scaled by 255
  localparam int unsigned ProdW = AccW + 8;

  // Smallest biased exponent that means a magnitude of at least one
  localparam logic [7:0] ExpOne = 8'd127;

  // Smallest biased exponent with no fraction bits left
  localparam logic [7:0] ExpInt = 8'd150;

  // Exponent bias that turns the exponent field into a fixed-point shift
  localparam logic [7:0] ShiftBias = 8'd102;

  // Exponent that leaves all 24 significand bits in the fraction
  localparam logic [7:0] ExpMaskBase = 8'd126;

  localparam logic [7:0] ByteFull = 8'hFF;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Conversion selected by the mode register
  typedef enum logic [1:0] {
    MODE_DEPTH   = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_ID      = 2'd2,
    MODE_PRIMVAR = 2'd3
  } mode_e;

  // Per-stage load enables from the flow control
  typedef struct packed {
    logic [NStage-1:0] load;
  } flow_t;

endpackage

`default_nettype wire

// ----- rtl/core/apc_pix_in_if.sv -----
// ----------------------------------------------------------------------------
// apc_pix_in_if
// Input pixel channel: three raw channel words and the end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface apc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic        last_in;

  modport source (
    output valid, word_a, word_b, word_c, last_in,
    input  ready
  );

  modport sink (
    input  valid, word_a, word_b, word_c, last_in,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/apc_pix_out_if.sv -----
// ----------------------------------------------------------------------------
// apc_pix_out_if
// Output pixel channel: one RGBA8 display pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface apc_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_out;

  modport source (
    output valid, red, green, blue, alpha, last_out,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha, last_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/aov_pixel_colorizer.sv -----
// ----------------------------------------------------------------------------
// aov_pixel_colorizer
// Throughput: one pixel per cycle unless the sink stalls; every stage can
// load in each cycle. The last stage is the output register; it holds while
// the sink stalls and earlier stages keep filling bubbles.
// Reset clears the mode register (clip depth) and all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aov_pixel_colorizer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  apc_pix_in_if.sink    pix_i,
  apc_pix_out_if.source pix_o
);

  // Hold the mode register
  apc_pkg::mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= apc_pkg::MODE_DEPTH;
    end else if (cfg_we_i) begin
      mode_q <= apc_pkg::mode_e'(cfg_wdata_i);
    end
  end

  // Flow control
  apc_pkg::flow_t flow;
  logic           out_valid;

  apc_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_ready_i (pix_o.ready),
    .out_valid_o (out_valid),
    .flow_o      (flow)
  );

  // Route words: depth and id modes drive every channel from the first word
  logic        multi_chan;
  logic [31:0] word_g;
  logic [31:0] word_b;

  assign multi_chan = (mode_q == apc_pkg::MODE_NORMAL) ||
                      (mode_q == apc_pkg::MODE_PRIMVAR);
  assign word_g     = multi_chan ? pix_i.word_b : pix_i.word_a;
  assign word_b     = multi_chan ? pix_i.word_c : pix_i.word_a;

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  apc_chan u_chan_r (
    .clk_i     (clk_i),
    .flow_i    (flow),
    .mode_i    (mode_q),
    .word_i    (pix_i.word_a),
    .id_byte_i (pix_i.word_a[7:0]),
    .byte_o    (red)
  );

  apc_chan u_chan_g (
    .clk_i     (clk_i),
    .flow_i    (flow),
    .mode_i    (mode_q),
    .word_i    (word_g),
    .id_byte_i (pix_i.word_a[15:8]),
    .byte_o    (green)
  );

  apc_chan u_chan_b (
    .clk_i     (clk_i),
    .flow_i    (flow),
    .mode_i    (mode_q),
    .word_i    (word_b),
    .id_byte_i (pix_i.word_a[23:16]),
    .byte_o    (blue)
  );

  // Carry the end-of-frame flag alongside the channels
  logic [apc_pkg::NStage-1:0] last_q;

  always_ff @(posedge clk_i) begin
    if (flow.load[0]) begin
      last_q[0] <= pix_i.last_in;
    end
    for (int k = 1; k < apc_pkg::NStage; k++) begin
      if (flow.load[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // Drive the output beat
  assign pix_o.valid    = out_valid;
  assign pix_o.red      = red;
  assign pix_o.green    = green;
  assign pix_o.blue     = blue;
  assign pix_o.alpha    = apc_pkg::AlphaOpaque;
  assign pix_o.last_out = last_q[apc_pkg::NStage-1];

endmodule

`default_nettype wire

// ----- rtl/core/apc_flow.sv -----
// ----------------------------------------------------------------------------
// apc_flow
// Valid bits and load enables of the pixel pipeline. Each stage loads when
// it is empty or when the stage after it loads, so bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_flow (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output apc_pkg::flow_t     flow_o
);

  logic [apc_pkg::NStage-1:0] valid_q;
  logic [apc_pkg::NStage-1:0] valid_d;
  logic [apc_pkg::NStage-1:0] load;

  // Build the load chain from the output back to the input
  always_comb begin
    load[apc_pkg::NStage-1] = !valid_q[apc_pkg::NStage-1] || out_ready_i;
    for (int k = apc_pkg::NStage - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  // Advance valid bits along with the data
  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < apc_pkg::NStage; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[apc_pkg::NStage-1];
  assign flow_o.load = load;

endmodule

`default_nettype wire

// ----- rtl/core/apc_chan.sv -----
// ----------------------------------------------------------------------------
// apc_chan
// One color channel: decode the float, align it to 48-bit fixed point, offset,
// scale by 255 and take the byte, or force a fixed byte. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_chan (
  input  wire logic           clk_i,
  input  wire apc_pkg::flow_t flow_i,
  input  wire apc_pkg::mode_e mode_i,
  input  wire logic [31:0]    word_i,
  input  wire logic [7:0]     id_byte_i,
  output logic [7:0]          byte_o
);

  localparam int unsigned FB = apc_pkg::FracBits;
  localparam int unsigned AW = apc_pkg::AccW;
  localparam int unsigned PW = apc_pkg::ProdW;
  localparam logic [AW-1:0] One = AW'(1) << FB;

  // ---------------- stage 1: decode ----------------
  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        nan;
  logic [23:0] mant;
  logic [7:0]  ex_norm;
  logic [23:0] frac_mask;
  logic [23:0] frac_bits;

  logic        force_d;
  logic [7:0]  fbyte_d;
  logic [23:0] val_d;
  logic [7:0]  sh_d;
  logic        neg_d;
  logic        unit_d;

  assign sgn     = word_i[31];
  assign ex      = word_i[30:23];
  assign fr      = word_i[22:0];
  assign nan     = (ex == 8'hFF) && (fr != '0);
  assign mant    = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
  assign ex_norm = (ex == 8'd0) ? 8'd1 : ex;

  // Keep only the bits below the binary point
  assign frac_mask = (ex <= apc_pkg::ExpMaskBase) ? 24'hFFFFFF
                   : (24'hFFFFFF >> (ex - apc_pkg::ExpMaskBase));
  assign frac_bits = mant & frac_mask;

  // Pick a fixed byte or set up the arithmetic path
  always_comb begin
    force_d = 1'b1;
    fbyte_d = 8'd0;
    val_d   = mant;
    sh_d    = ex_norm - apc_pkg::ShiftBias;
    neg_d   = sgn;
    unit_d  = 1'b1;
    unique case (mode_i)
      apc_pkg::MODE_DEPTH: begin
        // NaN, far plane and beyond, and minus one and below all draw black
        if (!nan && (ex < apc_pkg::ExpOne)) begin
          force_d = 1'b0;
        end
      end
      apc_pkg::MODE_NORMAL: begin
        if (nan) begin
          fbyte_d = 8'd0;
        end else if (ex >= apc_pkg::ExpOne) begin
          fbyte_d = sgn ? 8'd0 : apc_pkg::ByteFull;
        end else begin
          force_d = 1'b0;
        end
      end
      apc_pkg::MODE_ID: begin
        fbyte_d = id_byte_i;
      end
      apc_pkg::MODE_PRIMVAR: begin
        unit_d = 1'b0;
        val_d  = frac_bits;
        // Integers, infinities and NaN have no fraction
        if ((ex < apc_pkg::ExpInt) && (frac_bits != '0)) begin
          force_d = 1'b0;
        end
      end
      default: begin
        force_d = 1'b1;
      end
    endcase
  end

  logic        s1_force_q;
  logic [7:0]  s1_fbyte_q;
  logic [23:0] s1_val_q;
  logic [7:0]  s1_sh_q;
  logic        s1_neg_q;
  logic        s1_unit_q;

  always_ff @(posedge clk_i) begin
    if (flow_i.load[0]) begin
      s1_force_q <= force_d;
      s1_fbyte_q <= fbyte_d;
      s1_val_q   <= val_d;
      s1_sh_q    <= sh_d;
      s1_neg_q   <= neg_d;
      s1_unit_q  <= unit_d;
    end
  end

  // ---------------- stage 2: align to fixed point ----------------
  logic [7:0]    rsh;
  logic [23:0]   low_mask;
  logic          sticky;
  logic [FB-1:0] fix_d;

  assign rsh      = 8'd0 - s1_sh_q;
  assign low_mask = ~(24'hFFFFFF << rsh[4:0]);
  assign sticky   = (s1_val_q & low_mask) != '0;

  // Shift left, or shift right and round up on any lost bit
  always_comb begin
    if (!s1_sh_q[7]) begin
      fix_d = FB'(s1_val_q) << s1_sh_q[5:0];
    end else if (rsh >= 8'd32) begin
      fix_d = FB'(s1_val_q != '0);
    end else begin
      fix_d = FB'(s1_val_q >> rsh[4:0]) + FB'(sticky);
    end
  end

  logic          s2_force_q;
  logic [7:0]    s2_fbyte_q;
  logic [FB-1:0] s2_fix_q;
  logic          s2_neg_q;
  logic          s2_unit_q;

  always_ff @(posedge clk_i) begin
    if (flow_i.load[1]) begin
      s2_force_q <= s1_force_q;
      s2_fbyte_q <= s1_fbyte_q;
      s2_fix_q   <= fix_d;
      s2_neg_q   <= s1_neg_q;
      s2_unit_q  <= s1_unit_q;
    end
  end

  // ---------------- stage 3: offset ----------------
  logic [AW-1:0] acc_d;

  // Unit map adds one; a negative fraction wraps up from one
  always_comb begin
    if (s2_neg_q) begin
      acc_d = One - AW'(s2_fix_q);
    end else if (s2_unit_q) begin
      acc_d = One + AW'(s2_fix_q);
    end else begin
      acc_d = AW'(s2_fix_q);
    end
  end

  logic          s3_force_q;
  logic [7:0]    s3_fbyte_q;
  logic [AW-1:0] s3_acc_q;
  logic          s3_unit_q;

  always_ff @(posedge clk_i) begin
    if (flow_i.load[2]) begin
      s3_force_q <= s2_force_q;
      s3_fbyte_q <= s2_fbyte_q;
      s3_acc_q   <= acc_d;
      s3_unit_q  <= s2_unit_q;
    end
  end

  // ---------------- stage 4: scale by 255 and take the byte ----------------
  logic [PW-1:0] prod;
  logic [7:0]    byte_d;

  assign prod = {s3_acc_q, 8'd0} - PW'(s3_acc_q);

  always_comb begin
    if (s3_force_q) begin
      byte_d = s3_fbyte_q;
    end else if (s3_unit_q) begin
      byte_d = prod[PW-1 -: 8];
    end else begin
      byte_d = prod[PW-2 -: 8];
    end
  end

  logic [7:0] s4_byte_q;

  always_ff @(posedge clk_i) begin
    if (flow_i.load[3]) begin
      s4_byte_q <= byte_d;
    end
  end

  assign byte_o = s4_byte_q;

endmodule

`default_nettype wire

// ----- bench/apc_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// apc_pixel_checker
// Watches the pixel channels of the colorizer and tracks the mode register.
// Every input beat gets its display pixel predicted. Every output beat is
// compared with the oldest prediction. The result is a mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_pixel_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  apc_pix_in_if           pix_in_i,
  apc_pix_out_if          pix_out_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o
);

  localparam int FixBits = 48;
  localparam logic [63:0] FixOne = 64'd1 << FixBits;
  localparam int ReportMax = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_t;

  apc_pkg::mode_e mode_q;
  rgba_t expected_pixels[$];
  rgba_t want;
  rgba_t got;
  int    mismatches;
  int    checked;

  // Magnitude mant * 2^pw below one, as a 48-bit fraction; round up lost bits
  function automatic logic [63:0] to_fix48(logic [63:0] mant, int pw);
    int sh;
    int k;
    logic [63:0] q;
    sh = pw + FixBits;
    if (sh >= 0) return mant << sh;
    k = -sh;
    if (k >= 32) return (mant != 64'd0) ? 64'd1 : 64'd0;
    q = mant >> k;
    if ((mant & ((64'd1 << k) - 64'd1)) != 64'd0) q = q + 64'd1;
    return q;
  endfunction

  // Split IEEE single bits into sign, exponent field, significand and power
  function automatic void split_word(input logic [31:0] w, output logic sgn,
                                     output logic [7:0] ex,
                                     output logic [63:0] mant, output int pw);
    sgn = w[31];
    ex  = w[30:23];
    if (ex == 8'd0) begin
      mant = {41'd0, w[22:0]};
      pw   = -149;
    end else begin
      mant = {40'd0, 1'b1, w[22:0]};
      pw   = int'(ex) - 150;
    end
  endfunction

  // Map -1..1 onto 0..255, saturating; NaN gives zero
  function automatic logic [7:0] unit_byte(logic [31:0] w);
    logic        sgn;
    logic [7:0]  ex;
    logic [63:0] mant;
    logic [63:0] acc;
    logic [63:0] prod;
    int          pw;
    split_word(w, sgn, ex, mant, pw);
    if (ex == 8'hFF && w[22:0] != 23'd0) return 8'h00;
    if (ex >= 8'd127) return sgn ? 8'h00 : 8'hFF;
    acc  = to_fix48(mant, pw);
    acc  = sgn ? FixOne - acc : FixOne + acc;
    prod = (64'd255 * acc) >> (FixBits + 1);
    return prod[7:0];
  endfunction

  // Clip depth: black at or beyond the far plane, else the unit map
  function automatic logic [7:0] depth_byte(logic [31:0] w);
    logic is_nan;
    is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
    if (!is_nan && !w[31] && w[30:23] >= 8'd127) return 8'h00;
    return unit_byte(w);
  endfunction

  // Fractional part x - floor(x) scaled to a byte
  function automatic logic [7:0] frac_byte(logic [31:0] w);
    logic        sgn;
    logic [7:0]  ex;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] prod;
    int          pw;
    int          k;
    split_word(w, sgn, ex, mant, pw);
    if (ex == 8'hFF || pw >= 0) return 8'h00;
    k   = -pw;
    rem = (k >= 24) ? mant : (mant & ((64'd1 << k) - 64'd1));
    if (rem == 64'd0) return 8'h00;
    acc = to_fix48(rem, pw);
    if (sgn) acc = FixOne - acc;
    prod = (64'd255 * acc) >> FixBits;
    return prod[7:0];
  endfunction

  function automatic rgba_t colorize_pixel(apc_pkg::mode_e m, logic [31:0] a,
                                           logic [31:0] b, logic [31:0] c,
                                           logic lst);
    rgba_t px;
    px.alpha = apc_pkg::AlphaOpaque;
    px.last  = lst;
    case (m)
      apc_pkg::MODE_DEPTH: begin
        px.red   = depth_byte(a);
        px.green = px.red;
        px.blue  = px.red;
      end
      apc_pkg::MODE_NORMAL: begin
        px.red   = unit_byte(a);
        px.green = unit_byte(b);
        px.blue  = unit_byte(c);
      end
      apc_pkg::MODE_ID: begin
        px.red   = a[7:0];
        px.green = a[15:8];
        px.blue  = a[23:16];
      end
      default: begin
        px.red   = frac_byte(a);
        px.green = frac_byte(b);
        px.blue  = frac_byte(c);
      end
    endcase
    return px;
  endfunction

  // Track the mode, queue predictions, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= apc_pkg::MODE_DEPTH;
      expected_pixels.delete();
      mismatches = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (pix_out_i.valid && pix_out_i.ready) begin
        got = '{pix_out_i.red, pix_out_i.green, pix_out_i.blue, pix_out_i.alpha,
                pix_out_i.last_out};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("unexpected output beat: r=%h g=%h b=%h a=%h last=%b",
                     got.red, got.green, got.blue, got.alpha, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("pixel %0d: expected rgba %h%h%h%h last %b, got rgba %h%h%h%h last %b",
                       checked, want.red, want.green, want.blue, want.alpha, want.last,
                       got.red, got.green, got.blue, got.alpha, got.last);
          end
          checked++;
        end
      end
      if (pix_in_i.valid && pix_in_i.ready)
        expected_pixels.push_back(colorize_pixel(mode_q, pix_in_i.word_a, pix_in_i.word_b,
                                                 pix_in_i.word_c, pix_in_i.last_in));
      if (cfg_we_i) mode_q <= apc_pkg::mode_e'(cfg_wdata_i);
      fail_count_o <= mismatches;
      pending_o <= expected_pixels.size();
      checked_o <= checked;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the AOV pixel colorizer.
// Drives special float patterns in every mode, then random pixels under
// three idle profiles, while the checker compares every output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int RandPerMode = 100;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  int         gap_pct;
  int         stall_pct;
  int         sent_count;
  int         fail_count;
  int         pending;
  int         checked;

  apc_pix_in_if  pix_in ();
  apc_pix_out_if pix_out ();

  aov_pixel_colorizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  apc_pixel_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pix_in_i     (pix_in),
    .pix_out_i    (pix_out),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // Stall the output channel at random
  always @(posedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Float patterns at the edges of each conversion
  function automatic logic [31:0] special_word(int idx);
    case (idx)
      0:  return 32'h0000_0000; // +0
      1:  return 32'h8000_0000; // -0
      2:  return 32'h3F80_0000; // 1.0
      3:  return 32'hBF80_0000; // -1.0
      4:  return 32'h7F80_0000; // +inf
      5:  return 32'hFF80_0000; // -inf
      6:  return 32'h7FC0_0000; // quiet NaN
      7:  return 32'hFFFF_FFFF; // negative NaN, all ones
      8:  return 32'h0000_0001; // smallest denormal
      9:  return 32'h8000_0001; // smallest negative denormal
      10: return 32'h3F7F_FFFF; // just below one
      11: return 32'hBF7F_FFFF; // just above minus one
      12: return 32'h3F00_0000; // 0.5
      13: return 32'h4B00_0001; // integer, no fraction bits
      14: return 32'h3FC0_0000; // 1.5
      15: return 32'hC020_0000; // -2.5
      16: return 32'h7F7F_FFFF; // largest finite
      default: return 32'hFF7F_FFFF; // most negative finite
    endcase
  endfunction

  // Mostly values near the interesting range, some raw bits and specials
  function automatic logic [31:0] rand_word();
    logic [7:0] ex;
    case ($urandom_range(9))
      0: return $urandom();
      1: return special_word($urandom_range(17));
      default: begin
        ex = 8'($urandom_range(152, 96));
        return {1'($urandom_range(1)), ex, 23'($urandom())};
      end
    endcase
  endfunction

  // Present one beat after a random gap; hold until accepted
  task automatic send_pixel(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic lst);
    while ($urandom_range(99) < gap_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid   <= 1'b1;
    pix_in.word_a  <= a;
    pix_in.word_b  <= b;
    pix_in.word_c  <= c;
    pix_in.last_in <= lst;
    do @(posedge clk_i); while (!pix_in.ready);
    sent_count++;
  endtask

  // Drop valid and wait for every predicted pixel to come out
  task automatic drain_pipe();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (apc_pkg::NStage + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(input apc_pkg::mode_e m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = apc_pkg::MODE_DEPTH;
    pix_in.valid   = 1'b0;
    pix_in.word_a  = '0;
    pix_in.word_b  = '0;
    pix_in.word_c  = '0;
    pix_in.last_in = 1'b0;
    gap_pct        = 16;
    stall_pct      = 53;
    sent_count     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all special patterns in every mode
    for (int m = 0; m < 4; m++) begin
      write_mode(apc_pkg::mode_e'(m));
      for (int i = 0; i < 6; i++)
        send_pixel(special_word(3 * i), special_word(3 * i + 1), special_word(3 * i + 2),
                   1'(i));
      drain_pipe();
    end

    // Random: three idle profiles, each through all modes
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin gap_pct = 16; stall_pct = 53; end
        1: begin gap_pct = 53; stall_pct = 16; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int m = 0; m < 4; m++) begin
        write_mode(apc_pkg::mode_e'((m + p) % 4));
        repeat (RandPerMode)
          send_pixel(rand_word(), rand_word(), rand_word(), 1'($urandom_range(1)));
        drain_pipe();
      end
    end

    repeat (4 * apc_pkg::NStage) @(posedge clk_i);
    $display("Sent %0d pixels, checked %0d: specials in all four modes,", sent_count, checked);
    $display("then random pixels in each mode under three idle profiles.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/apc_pkg.sv
rtl/core/apc_pix_in_if.sv
rtl/core/apc_pix_out_if.sv
rtl/core/apc_flow.sv
rtl/core/apc_chan.sv
rtl/core/aov_pixel_colorizer.sv
bench/apc_pixel_checker.sv
bench/tb_top.sv
